// ===== design/stl_pkg.sv =====
// Shared types, token kind codes and keyword table for the script token lexer.
package stl_pkg;

    typedef logic [5:0] t_kind;

    typedef enum logic [3:0] {
        ST_START   = 4'd0,
        ST_IDENT   = 4'd1,
        ST_NUM     = 4'd2,
        ST_FRAC    = 4'd3,
        ST_STR     = 4'd4,
        ST_LT      = 4'd5,
        ST_GT      = 4'd6,
        ST_EQ      = 4'd7,
        ST_BANG    = 4'd8,
        ST_SLASH   = 4'd9,
        ST_COMMENT = 4'd10
    } t_scan_state;

    localparam t_kind KIND_NUMBER     = 6'd0;
    localparam t_kind KIND_IDENT      = 6'd1;
    localparam t_kind KIND_STRING     = 6'd2;
    localparam t_kind KIND_PLUS       = 6'd3;
    localparam t_kind KIND_MINUS      = 6'd4;
    localparam t_kind KIND_LESS       = 6'd5;
    localparam t_kind KIND_LESS_EQ    = 6'd6;
    localparam t_kind KIND_GREATER    = 6'd7;
    localparam t_kind KIND_GREATER_EQ = 6'd8;
    localparam t_kind KIND_ASSIGN     = 6'd9;
    localparam t_kind KIND_EQ_EQ      = 6'd10;
    localparam t_kind KIND_BANG       = 6'd11;
    localparam t_kind KIND_BANG_EQ    = 6'd12;
    localparam t_kind KIND_DOT        = 6'd13;
    localparam t_kind KIND_SLASH      = 6'd14;
    localparam t_kind KIND_STAR       = 6'd15;
    localparam t_kind KIND_LPAREN     = 6'd16;
    localparam t_kind KIND_RPAREN     = 6'd17;
    localparam t_kind KIND_LBRACE     = 6'd18;
    localparam t_kind KIND_RBRACE     = 6'd19;
    localparam t_kind KIND_SEMICOLON  = 6'd20;
    localparam t_kind KIND_COMMA      = 6'd21;
    localparam t_kind KIND_KW_FIRST   = 6'd22;
    localparam t_kind KIND_END        = 6'd38;
    localparam t_kind KIND_ERROR      = 6'd39;

    localparam int KW_COUNT    = 16;
    localparam int KW_MAX_CHARS = 6;

    // Keyword text, right aligned: last character in the low byte.
    localparam logic [8*KW_MAX_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
        48'("and"),   48'("class"),  48'("else"),  48'("false"),
        48'("for"),   48'("fun"),    48'("if"),    48'("nil"),
        48'("or"),    48'("print"),  48'("return"), 48'("super"),
        48'("this"),  48'("true"),   48'("var"),   48'("while")
    };

    localparam int KW_LEN [KW_COUNT] = '{
        3, 5, 4, 5, 3, 3, 2, 3, 2, 5, 6, 5, 4, 4, 3, 5
    };

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = 2;
    localparam int FIFO_CNT_BITS = 3;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_input;
    } t_src_item;

    typedef struct packed {
        t_kind       token_kind;
        logic [31:0] token_offset;
        logic [31:0] token_length;
        logic [31:0] line_number;
        logic [31:0] column_number;
        logic        last_of_run;
    } t_token;

endpackage

// ===== design/stl_stream_if.sv =====
// Valid/ready stream interface carrying one payload per transaction.
interface stl_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

// ===== design/script_token_lexer.sv =====
// Streaming lexer: one source byte in per transaction, tokens out with position info.
//
// Usage:
//   i_src carries one source byte (or the end marker) per transaction; o_tok
//   carries one token per transaction. A byte yields zero, one or two tokens;
//   last_of_run flags the final token a byte produced.
//   A token is registered in the result queue when the byte that caused it is
//   accepted, and o_tok shows the queue head. Throughput: one byte per cycle
//   while i_src.ready is high; the scanner state, position counters and keyword
//   compare settle between the state registers and a four-entry result queue.
//   The queue drains one token per cycle while o_tok.ready is high, so a run of
//   bytes that each yield two tokens is limited by the output side.
//   i_src.ready is high while the queue has room for two tokens; when the
//   receiver stalls, the queue fills and input is held off, nothing is lost.
//   The end marker flushes the pending token, emits an end token and returns
//   the scanner state and all position counters to the start of a new source text.
//   Reset (synchronous, active low) empties the queue, puts the scanner in its
//   start state at offset zero, line one; no transaction is taken during reset.
module script_token_lexer #(
    parameter int PREFIX_CHARS  = 6,
    parameter int POSITION_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    stl_stream_if.sink   i_src,
    stl_stream_if.source o_tok
);

    localparam int IDXW = (PREFIX_CHARS > 1) ? $clog2(PREFIX_CHARS) : 1;
    localparam int PW   = POSITION_BITS;
    localparam int KWB  = 8 * stl_pkg::KW_MAX_CHARS;
    localparam logic [7:0] CH_CR = 8'h0D;

    typedef logic [PW-1:0] t_pos;

    function automatic t_pos sat_inc(input t_pos x);
        return (x == '1) ? x : x + t_pos'(1);
    endfunction

    function automatic t_pos pos_diff(input t_pos a, input t_pos b);
        return (a >= b) ? a - b : '0;
    endfunction

    function automatic logic [31:0] to32(input t_pos x);
        logic [PW+31:0] w;
        w = {32'b0, x};
        return w[31:0];
    endfunction

    function automatic logic is_alpha(input logic [7:0] ch);
        return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    // scanner state
    stl_pkg::t_scan_state r_state, n_state;
    t_pos r_pos, n_pos;
    t_pos r_tok_begin, n_tok_begin;
    t_pos r_line, n_line;
    t_pos r_line_begin, n_line_begin;
    t_pos r_tok_line_begin, n_tok_line_begin;
    t_pos r_tok_line, n_tok_line;
    logic [7:0] r_prefix [PREFIX_CHARS];

    // result queue
    stl_pkg::t_token r_fifo [stl_pkg::FIFO_DEPTH];
    logic [stl_pkg::FIFO_PTR_BITS-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [stl_pkg::FIFO_CNT_BITS-1:0] r_count, n_count;

    logic       acc, pop, eoi;
    logic [7:0] c;

    t_pos pend_len, pend_col, cur_col;
    logic [KWB-1:0] word;
    stl_pkg::t_kind ident_kind;

    logic           p_fire, s_run, s_fire, e_fire, newline;
    stl_pkg::t_kind p_kind, s_kind;
    t_pos           p_len;
    logic           pf_we;
    logic [IDXW-1:0] pf_idx;

    stl_pkg::t_token res0, res1, pend_rec, cur_rec;
    logic [1:0]      push;

    assign i_src.ready = i_rst_n && (r_count <= stl_pkg::FIFO_CNT_BITS'(2));
    assign acc   = i_src.valid && i_src.ready;
    assign c     = i_src.payload.source_byte;
    assign eoi   = i_src.payload.end_of_input;

    assign o_tok.valid   = (r_count != '0);
    assign o_tok.payload = r_fifo[r_rd];
    assign pop           = o_tok.valid && o_tok.ready;

    assign pend_len = pos_diff(r_pos, r_tok_begin);
    assign pend_col = sat_inc(pos_diff(r_tok_begin, r_tok_line_begin));
    assign cur_col  = sat_inc(pos_diff(r_pos, r_line_begin));

    // keyword compare over the first characters of the pending identifier
    always_comb begin
        word = '0;
        for (int j = 0; j < stl_pkg::KW_MAX_CHARS; j++) begin
            word[8*(stl_pkg::KW_MAX_CHARS-1-j) +: 8] = r_prefix[IDXW'(j)];
        end
        ident_kind = stl_pkg::KIND_IDENT;
        for (int i = 0; i < stl_pkg::KW_COUNT; i++) begin
            if (pend_len == t_pos'(stl_pkg::KW_LEN[i]) &&
                (word >> (8 * (stl_pkg::KW_MAX_CHARS - stl_pkg::KW_LEN[i])))
                    == stl_pkg::KW_TEXT[i]) begin
                ident_kind = stl_pkg::KIND_KW_FIRST + stl_pkg::t_kind'(i);
            end
        end
    end

    always_comb begin
        n_state          = r_state;
        n_pos            = r_pos;
        n_tok_begin      = r_tok_begin;
        n_line           = r_line;
        n_line_begin     = r_line_begin;
        n_tok_line_begin = r_tok_line_begin;
        n_tok_line       = r_tok_line;
        p_fire  = 1'b0;
        p_kind  = stl_pkg::KIND_ERROR;
        p_len   = '0;
        s_run   = 1'b0;
        s_fire  = 1'b0;
        s_kind  = stl_pkg::KIND_ERROR;
        e_fire  = 1'b0;
        newline = 1'b0;
        pf_we   = 1'b0;
        pf_idx  = '0;

        if (acc && eoi) begin
            e_fire = 1'b1;
            case (r_state)
                stl_pkg::ST_IDENT: begin
                    p_fire = 1'b1; p_kind = ident_kind; p_len = pend_len;
                end
                stl_pkg::ST_NUM, stl_pkg::ST_FRAC: begin
                    p_fire = 1'b1; p_kind = stl_pkg::KIND_NUMBER; p_len = pend_len;
                end
                stl_pkg::ST_STR: begin
                    p_fire = 1'b1; p_kind = stl_pkg::KIND_ERROR; p_len = pend_len;
                end
                stl_pkg::ST_LT: begin
                    p_fire = 1'b1; p_kind = stl_pkg::KIND_LESS; p_len = t_pos'(1);
                end
                stl_pkg::ST_GT: begin
                    p_fire = 1'b1; p_kind = stl_pkg::KIND_GREATER; p_len = t_pos'(1);
                end
                stl_pkg::ST_EQ: begin
                    p_fire = 1'b1; p_kind = stl_pkg::KIND_ASSIGN; p_len = t_pos'(1);
                end
                stl_pkg::ST_BANG: begin
                    p_fire = 1'b1; p_kind = stl_pkg::KIND_BANG; p_len = t_pos'(1);
                end
                stl_pkg::ST_SLASH: begin
                    p_fire = 1'b1; p_kind = stl_pkg::KIND_SLASH; p_len = t_pos'(1);
                end
                default: begin
                end
            endcase
        end else if (acc) begin
            case (r_state)
                stl_pkg::ST_IDENT: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        if (pend_len < t_pos'(PREFIX_CHARS)) begin
                            pf_we  = 1'b1;
                            pf_idx = pend_len[IDXW-1:0];
                        end
                    end else begin
                        p_fire = 1'b1; p_kind = ident_kind; p_len = pend_len;
                        s_run  = 1'b1;
                    end
                end
                stl_pkg::ST_NUM, stl_pkg::ST_FRAC: begin
                    if (is_digit(c)) begin
                    end else if (c == "." && r_state == stl_pkg::ST_NUM) begin
                        n_state = stl_pkg::ST_FRAC;
                    end else begin
                        p_fire = 1'b1; p_kind = stl_pkg::KIND_NUMBER; p_len = pend_len;
                        s_run  = 1'b1;
                    end
                end
                stl_pkg::ST_STR: begin
                    if (c == "\"") begin
                        p_fire  = 1'b1; p_kind = stl_pkg::KIND_STRING; p_len = pend_len;
                        n_state = stl_pkg::ST_START;
                    end else if (c == "\n") begin
                        newline = 1'b1;
                    end
                end
                stl_pkg::ST_LT, stl_pkg::ST_GT, stl_pkg::ST_EQ, stl_pkg::ST_BANG: begin
                    p_fire = 1'b1;
                    case (r_state)
                        stl_pkg::ST_LT: p_kind = (c == "=") ? stl_pkg::KIND_LESS_EQ
                                                            : stl_pkg::KIND_LESS;
                        stl_pkg::ST_GT: p_kind = (c == "=") ? stl_pkg::KIND_GREATER_EQ
                                                            : stl_pkg::KIND_GREATER;
                        stl_pkg::ST_EQ: p_kind = (c == "=") ? stl_pkg::KIND_EQ_EQ
                                                            : stl_pkg::KIND_ASSIGN;
                        default:        p_kind = (c == "=") ? stl_pkg::KIND_BANG_EQ
                                                            : stl_pkg::KIND_BANG;
                    endcase
                    if (c == "=") begin
                        p_len   = t_pos'(2);
                        n_state = stl_pkg::ST_START;
                    end else begin
                        p_len = t_pos'(1);
                        s_run = 1'b1;
                    end
                end
                stl_pkg::ST_SLASH: begin
                    if (c == "/") begin
                        n_state = stl_pkg::ST_COMMENT;
                    end else begin
                        p_fire = 1'b1; p_kind = stl_pkg::KIND_SLASH; p_len = t_pos'(1);
                        s_run  = 1'b1;
                    end
                end
                stl_pkg::ST_COMMENT: begin
                    if (c == "\n") begin
                        newline = 1'b1;
                        n_state = stl_pkg::ST_START;
                    end
                end
                default: begin
                    s_run = 1'b1;
                end
            endcase
        end

        // rescan the current byte from the start state
        if (s_run) begin
            n_state = stl_pkg::ST_START;
            case (c)
                " ", "\t", CH_CR: begin
                end
                "\n": newline = 1'b1;
                "\"", "<", ">", "=", "!", "/": begin
                    n_tok_begin      = (c == "\"") ? sat_inc(r_pos) : r_pos;
                    n_tok_line_begin = r_line_begin;
                    n_tok_line       = r_line;
                    case (c)
                        "\"":    n_state = stl_pkg::ST_STR;
                        "<":     n_state = stl_pkg::ST_LT;
                        ">":     n_state = stl_pkg::ST_GT;
                        "=":     n_state = stl_pkg::ST_EQ;
                        "!":     n_state = stl_pkg::ST_BANG;
                        default: n_state = stl_pkg::ST_SLASH;
                    endcase
                end
                default: begin
                    n_tok_begin      = r_pos;
                    n_tok_line_begin = r_line_begin;
                    n_tok_line       = r_line;
                    case (c)
                        "+": begin s_fire = 1'b1; s_kind = stl_pkg::KIND_PLUS; end
                        "-": begin s_fire = 1'b1; s_kind = stl_pkg::KIND_MINUS; end
                        ".": begin s_fire = 1'b1; s_kind = stl_pkg::KIND_DOT; end
                        "*": begin s_fire = 1'b1; s_kind = stl_pkg::KIND_STAR; end
                        "(": begin s_fire = 1'b1; s_kind = stl_pkg::KIND_LPAREN; end
                        ")": begin s_fire = 1'b1; s_kind = stl_pkg::KIND_RPAREN; end
                        "{": begin s_fire = 1'b1; s_kind = stl_pkg::KIND_LBRACE; end
                        "}": begin s_fire = 1'b1; s_kind = stl_pkg::KIND_RBRACE; end
                        ";": begin s_fire = 1'b1; s_kind = stl_pkg::KIND_SEMICOLON; end
                        ",": begin s_fire = 1'b1; s_kind = stl_pkg::KIND_COMMA; end
                        default: begin
                            if (is_alpha(c)) begin
                                n_state = stl_pkg::ST_IDENT;
                                pf_we   = 1'b1;
                                pf_idx  = '0;
                            end else if (is_digit(c)) begin
                                n_state = stl_pkg::ST_NUM;
                            end else begin
                                s_fire = 1'b1;
                                s_kind = stl_pkg::KIND_ERROR;
                            end
                        end
                    endcase
                end
            endcase
        end

        if (newline) begin
            n_line       = sat_inc(r_line);
            n_line_begin = sat_inc(r_pos);
        end

        if (acc && !eoi) begin
            n_pos = sat_inc(r_pos);
        end

        // end marker restarts the scanner state and every position counter
        if (e_fire) begin
            n_state          = stl_pkg::ST_START;
            n_pos            = '0;
            n_tok_begin      = '0;
            n_line           = t_pos'(1);
            n_line_begin     = '0;
            n_tok_line_begin = '0;
            n_tok_line       = t_pos'(1);
        end
    end

    // assemble up to two tokens for this byte
    always_comb begin
        pend_rec.token_kind    = p_kind;
        pend_rec.token_offset  = to32(r_tok_begin);
        pend_rec.token_length  = to32(p_len);
        pend_rec.line_number   = to32(r_tok_line);
        pend_rec.column_number = to32(pend_col);
        pend_rec.last_of_run   = !(s_fire || e_fire);

        cur_rec.token_kind    = s_fire ? s_kind : stl_pkg::KIND_END;
        cur_rec.token_offset  = to32(r_pos);
        cur_rec.token_length  = s_fire ? 32'd1 : 32'd0;
        cur_rec.line_number   = to32(r_line);
        cur_rec.column_number = to32(cur_col);
        cur_rec.last_of_run   = 1'b1;

        if (p_fire) begin
            res0 = pend_rec;
            res1 = cur_rec;
            push = (s_fire || e_fire) ? 2'd2 : 2'd1;
        end else begin
            res0 = cur_rec;
            res1 = cur_rec;
            push = (s_fire || e_fire) ? 2'd1 : 2'd0;
        end

        n_wr    = r_wr + stl_pkg::FIFO_PTR_BITS'(push);
        n_rd    = r_rd + (pop ? stl_pkg::FIFO_PTR_BITS'(1) : '0);
        n_count = r_count + stl_pkg::FIFO_CNT_BITS'(push)
                  - (pop ? stl_pkg::FIFO_CNT_BITS'(1) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= stl_pkg::ST_START;
            r_pos            <= '0;
            r_tok_begin      <= '0;
            r_line           <= t_pos'(1);
            r_line_begin     <= '0;
            r_tok_line_begin <= '0;
            r_tok_line       <= t_pos'(1);
            r_wr             <= '0;
            r_rd             <= '0;
            r_count          <= '0;
        end else begin
            r_state          <= n_state;
            r_pos            <= n_pos;
            r_tok_begin      <= n_tok_begin;
            r_line           <= n_line;
            r_line_begin     <= n_line_begin;
            r_tok_line_begin <= n_tok_line_begin;
            r_tok_line       <= n_tok_line;
            r_wr             <= n_wr;
            r_rd             <= n_rd;
            r_count          <= n_count;
        end
    end

    // payload storage: identifier prefix and result queue
    always_ff @(posedge i_clk) begin
        if (pf_we) begin
            r_prefix[pf_idx] <= c;
        end
        if (push != 2'd0) begin
            r_fifo[r_wr] <= res0;
        end
        if (push == 2'd2) begin
            r_fifo[r_wr + stl_pkg::FIFO_PTR_BITS'(1)] <= res1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= stl_pkg::FIFO_CNT_BITS'(stl_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && eoi) |=> (r_state == stl_pkg::ST_START && r_pos == '0
                          && r_line == t_pos'(1)))
        else $error("end marker did not restart scanner");

    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && eoi) |=> (r_count != '0))
        else $error("end marker produced no token");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0 && r_tok_line != '0)
        else $error("line counter reached zero");

    a_tok_line_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tok_line <= r_line)
        else $error("pending token starts after current line");

endmodule
